>>> sv/substring_occurrence_finder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the substring occurrence finder
// Implication macros used by the port checker, clocked on clk and disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_OCCURRENCE_FINDER_TOP_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_FINDER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SOF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sof_checker: port property violated");

// Next-cycle implication.
`define SOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sof_checker: port property violated");

`endif

>>> sv/sof_pkg.sv
// ----------------------------------------------------------------------------
// Substring occurrence finder package
// Shared types and constants: register indexes, field widths and the result
// record that travels from the front end through the queue to the output.
// ----------------------------------------------------------------------------
`default_nettype none

package sof_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PATTERN_LEN   = 3'd0,
    CFG_PATTERN_WORD0 = 3'd1,
    CFG_PATTERN_WORD1 = 3'd2,
    CFG_PATTERN_WORD2 = 3'd3,
    CFG_PATTERN_WORD3 = 3'd4
  } cfg_reg_t;

  // Pattern storage.
  localparam int PAT_LEN_W = 6;
  localparam int PAT_WORDS = 4;
  localparam int PAT_BYTES = 32;

  // Result field widths.
  localparam int START_W = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // Result queue between front end and output stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // One result record.
  typedef struct packed {
    logic               too_long;
    logic [COUNT_W-1:0] match_total;
    logic               text_done;
    logic [START_W-1:0] match_start;
    logic               match_valid;
  } sof_result_t;

endpackage

`default_nettype wire

>>> sv/substring_occurrence_finder_top.sv
// Result path: a result passes through the result queue and then the output
// register before it is offered on the output.
// Throughput: one text byte per cycle; input stalls only while the four-entry
// result queue is full, as happens when the output is held off.
// Reset: synchronous, active low; clears the search state and the queue,
// sets pattern_len to 1 and all pattern words to zero.
// ----------------------------------------------------------------------------
// Substring occurrence finder top level
// Finds leftmost non-overlapping occurrences of a configured pattern in a
// byte stream and reports their start index and running count.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_occurrence_finder_top #(
  parameter int PATTERN_MAX = 32,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration port
  input  wire logic                            cfg_wr_en,
  input  wire logic [sof_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [sof_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Text stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sof_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] text_byte
  input  wire logic                            in_tlast,   // text_last
  // Result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [sof_pkg::OUT_DATA_W-1:0]       out_tdata,  // [15:0] match_start, [31:16] match_total
  output logic [sof_pkg::OUT_USER_W-1:0]       out_tuser,  // [0] match_valid, [1] too_long
  output logic                                 out_tlast   // text_done
);

  logic                 q_full, push_valid, q_pop, q_valid;
  sof_pkg::sof_result_t push_data, q_data;

  // Byte window, pattern compare and search state.
  sof_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Result queue.
  sof_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .q_valid    (q_valid),
    .q_data     (q_data)
  );

  // Output register and stream packing.
  sof_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> sv/sof_front.sv
// ----------------------------------------------------------------------------
// Substring occurrence finder front end
// Holds the pattern registers, the byte window and the text position state.
// Each accepted byte is compared against the pattern combinationally and, when
// it completes a match or ends the text, a result record is pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_front #(
  parameter int PATTERN_MAX = 32,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration writes
  input  wire logic                            cfg_wr_en,
  input  wire logic [sof_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [sof_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Text byte stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sof_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                            in_tlast,
  // Result queue push side
  input  wire logic                            q_full,
  output logic                                 push_valid,
  output sof_pkg::sof_result_t                 push_data
);

  localparam int WIN_IW = $clog2(PATTERN_MAX);
  localparam int PW     = INDEX_BITS + 1;
  localparam int LW     = sof_pkg::PAT_LEN_W;

  // Pattern registers.
  logic [LW-1:0]                  pat_len_r;
  logic [sof_pkg::CFG_DATA_W-1:0] pat_word_r [sof_pkg::PAT_WORDS];

  // Search state.
  logic [7:0]                 win_r [PATTERN_MAX];
  logic [INDEX_BITS-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]              nas_r, nas_nxt;
  logic [sof_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;

  logic [8*sof_pkg::PAT_BYTES-1:0] pat_flat;
  logic [7:0]             pat_byte [PATTERN_MAX];
  logic [7:0]             cand [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] byte_ok;
  logic [LW-1:0]          eff_len;
  logic [PW-1:0]          cur_p1, len_ext, start_w;
  logic [INDEX_BITS+sof_pkg::START_W-1:0] start_ext;
  logic [sof_pkg::COUNT_W-1:0] count_inc;
  logic                   accept, found;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Pattern bytes past the register file read as zero.
  assign pat_flat = {pat_word_r[3], pat_word_r[2], pat_word_r[1], pat_word_r[0]};
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    if (k < sof_pkg::PAT_BYTES) begin : g_reg
      assign pat_byte[k] = pat_flat[8*k +: 8];
    end else begin : g_zero
      assign pat_byte[k] = 8'd0;
    end
  end

  // Window as it stands after the incoming byte is shifted in.
  always_comb begin
    cand[0] = in_tdata;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      cand[j] = win_r[j-1];
    end
  end

  // Effective length: zero acts as one, oversize is clipped.
  always_comb begin
    eff_len = pat_len_r;
    if (pat_len_r == '0) begin
      eff_len = LW'(1);
    end else if (pat_len_r > LW'(PATTERN_MAX)) begin
      eff_len = LW'(PATTERN_MAX);
    end
  end

  // Pattern byte i must sit at window entry len-1-i.
  always_comb begin
    logic [LW-1:0] sel;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sel        = eff_len - LW'(i) - LW'(1);
      byte_ok[i] = (LW'(i) >= eff_len) || (cand[sel[WIN_IW-1:0]] == pat_byte[i]);
    end
  end

  // Position checks and match decision.
  assign cur_p1    = {1'b0, pos_r} + PW'(1);
  assign len_ext   = PW'(eff_len);
  assign start_w   = cur_p1 - len_ext;
  assign found     = !ovf_r && (cur_p1 >= len_ext) && (start_w >= nas_r) && (&byte_ok);
  assign count_inc = sof_pkg::COUNT_W'(found && (count_r != sof_pkg::COUNT_MAX));
  assign start_ext = {{sof_pkg::START_W{1'b0}}, start_w[INDEX_BITS-1:0]};

  // Next state of the search registers for an accepted byte.
  always_comb begin
    pos_nxt   = pos_r;
    nas_nxt   = nas_r;
    count_nxt = count_r + count_inc;
    ovf_nxt   = ovf_r;
    if (found) begin
      nas_nxt = cur_p1;
    end
    if (!ovf_r) begin
      if (&pos_r) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = cur_p1[INDEX_BITS-1:0];
      end
    end
    if (in_tlast) begin
      pos_nxt   = '0;
      nas_nxt   = '0;
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // Result record for this byte.
  always_comb begin
    push_valid            = accept && (found || in_tlast);
    push_data.match_valid = found;
    push_data.match_start = found ? start_ext[sof_pkg::START_W-1:0] : '0;
    push_data.text_done   = in_tlast;
    push_data.match_total = count_r + count_inc;
    push_data.too_long    = ovf_r;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= LW'(1);
      for (int w = 0; w < sof_pkg::PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        sof_pkg::CFG_PATTERN_LEN:   pat_len_r     <= cfg_wdata[LW-1:0];
        sof_pkg::CFG_PATTERN_WORD0: pat_word_r[0] <= cfg_wdata;
        sof_pkg::CFG_PATTERN_WORD1: pat_word_r[1] <= cfg_wdata;
        sof_pkg::CFG_PATTERN_WORD2: pat_word_r[2] <= cfg_wdata;
        sof_pkg::CFG_PATTERN_WORD3: pat_word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Search state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nas_r   <= '0;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      nas_r   <= nas_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Byte window; entries older than the text start are never compared.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_r[j] <= cand[j];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/sof_queue.sv
// ----------------------------------------------------------------------------
// Substring occurrence finder result queue
// Short first-in first-out buffer that decouples the front end from the
// output stage so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_valid,
  input  wire sof_pkg::sof_result_t push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output sof_pkg::sof_result_t      q_data
);

  localparam int AW = sof_pkg::QPTR_W;

  sof_pkg::sof_result_t slot_r [sof_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(sof_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = slot_r[rd_ptr_r];
  assign do_push = push_valid && !full;
  assign do_pop  = pop && q_valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/sof_back.sv
// ----------------------------------------------------------------------------
// Substring occurrence finder output stage
// Takes result records from the queue into an output register and packs
// them onto the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sof_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire sof_pkg::sof_result_t             q_data,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [sof_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic [sof_pkg::OUT_USER_W-1:0]        out_tuser,
  output logic                                  out_tlast
);

  logic                 out_valid_r, out_valid_nxt;
  sof_pkg::sof_result_t out_data_r;

  // Load a new record when the register is empty or being drained.
  assign q_pop         = q_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_data;
    end
  end

  // Stream packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.match_total, out_data_r.match_start};
  assign out_tuser  = {out_data_r.too_long, out_data_r.match_valid};
  assign out_tlast  = out_data_r.text_done;

endmodule

`default_nettype wire

>>> sv/sof_checker.sv
// ----------------------------------------------------------------------------
// Substring occurrence finder port checker
// Watches the result stream of the top level and checks the properties that
// every result transfer must have.
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_occurrence_finder_top_assert.svh"

module sof_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [sof_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire logic [sof_pkg::OUT_USER_W-1:0]   out_tuser,
  input wire logic                             out_tlast
);

  // A stalled result holds its contents.
  `SOF_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // Every result reports a match, the end of the text, or both.
  `SOF_ASSERT_IMPLIES(a_has_reason, out_tvalid, out_tuser[0] || out_tlast)

  // Without a match the start index reads as zero.
  `SOF_ASSERT_IMPLIES(a_start_zero, out_tvalid && !out_tuser[0], out_tdata[15:0] == 16'd0)

  // No match is reported once the text is past the index range.
  `SOF_ASSERT_IMPLIES(a_no_match_too_long, out_tvalid && out_tuser[1], !out_tuser[0])

endmodule

bind substring_occurrence_finder_top sof_checker u_sof_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
